/* hdl/isdi_pkg.sv */
// shared types and constants for the inverse-square distance interpolator
package isdi_pkg;

	localparam int VAL_W                 = 24;
	localparam int DIFF_W                = 25;
	localparam int SQ_W                  = 48;
	localparam int D2_W                  = 49;
	localparam int WT_W                  = 40;
	localparam int WVT_W                 = 64;
	localparam int DIVN_W                = 64;
	localparam int CNT_W                 = 7;
	localparam int CFG_IDX_W             = 1;
	localparam int WEIGHT_FRAC_BITS_DEF  = 24;

	localparam logic [CFG_IDX_W-1:0] REG_QUERY_X = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_QUERY_Z = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Z,
		ST_D2_SUM,
		ST_DIV_W,
		ST_MUL_V,
		ST_ACCUM,
		ST_FIN,
		ST_DIV_R,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		MUL_DX,
		MUL_DZ,
		MUL_WV
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     capture;
		logic     d2_save;
		logic     wdiv_load;
		logic     rdiv_load;
		logic     div_step;
		logic     acc_en;
		logic     fin_direct;
		logic     fin_quot;
	} ctl_t;

endpackage

/* hdl/inverse_square_distance_interpolator_core.sv */
// inverse-square distance interpolator core: sequencer, shared multiplier and shared divider
// a point without an exact hit keeps busy high while the shift-subtract divider forms its weight,
// one weight bit per cycle; an exact hit and the points after it skip the arithmetic
// the last point adds a 64-bit final division (skipped with a hit or no weight)
// done pulses for one cycle with the result, in the same cycle that busy falls; the receiver cannot stall it
// arst_n clears the query registers, the accumulators and the sequencer at once
module inverse_square_distance_interpolator_core #(
	parameter int WEIGHT_FRAC_BITS = isdi_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [isdi_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [isdi_pkg::VAL_W-1:0]            cfg_wdata,
	// request side
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [isdi_pkg::VAL_W-1:0]     sample_x,
	input  logic signed [isdi_pkg::VAL_W-1:0]     sample_z,
	input  logic signed [isdi_pkg::VAL_W-1:0]     sample_value,
	input  logic                                  last_point,
	// result side
	output logic                                  done,
	output logic signed [isdi_pkg::VAL_W-1:0]     interpolated_value,
	output logic                                  exact_hit,
	output logic                                  saturated
);

	// weight is floor(2^WEIGHT_FRAC_BITS / d2), at most 2^WEIGHT_FRAC_BITS
	localparam int QW   = WEIGHT_FRAC_BITS + 1;
	// multiplier operand a holds either a signed difference or a zero-extended weight
	localparam int MA_W = (QW + 1 > isdi_pkg::DIFF_W) ? QW + 1 : isdi_pkg::DIFF_W;
	localparam int P_W  = MA_W + isdi_pkg::DIFF_W;
	localparam int VW   = isdi_pkg::VAL_W;

	// query point registers
	logic signed [VW-1:0] query_x_q;
	logic signed [VW-1:0] query_z_q;

	// sequencer
	isdi_pkg::state_t state_q;
	isdi_pkg::state_t state_d;
	isdi_pkg::ctl_t   ctl;

	// captured point
	logic signed [isdi_pkg::DIFF_W-1:0] dx_q;
	logic signed [isdi_pkg::DIFF_W-1:0] dz_q;
	logic signed [VW-1:0]               value_q;
	logic                               last_q;
	logic signed [isdi_pkg::DIFF_W-1:0] dx_in;
	logic signed [isdi_pkg::DIFF_W-1:0] dz_in;
	logic                               new_hit;

	// set state
	logic [isdi_pkg::WT_W-1:0]          wt_q;
	logic signed [isdi_pkg::WVT_W-1:0]  wvt_q;
	logic                               hit_found_q;
	logic [VW-1:0]                      hit_value_q;
	logic                               ovf_q;
	logic                               neg_q;

	// shared multiplier
	logic signed [MA_W-1:0]              mul_a;
	logic signed [isdi_pkg::DIFF_W-1:0]  mul_b;
	logic signed [P_W-1:0]               mul_p;
	logic signed [P_W-1:0]               mul_q;
	logic [isdi_pkg::SQ_W-1:0]           d2_q;

	// shared shift-subtract divider
	logic [isdi_pkg::D2_W-1:0]   div_r_q;
	logic [isdi_pkg::D2_W-1:0]   div_d_q;
	logic [isdi_pkg::DIVN_W-1:0] div_n_q;
	logic [isdi_pkg::CNT_W-1:0]  cnt_q;
	logic [isdi_pkg::D2_W:0]     div_shift;
	logic [isdi_pkg::D2_W+1:0]   div_trial;
	logic                        div_ge;
	logic [QW-1:0]               weight;

	// accumulation
	logic [isdi_pkg::WT_W:0]          wt_sum;
	logic signed [isdi_pkg::WVT_W:0]  wvt_sum;
	logic                             wt_ovf;
	logic                             wvt_ovf;
	logic [isdi_pkg::WVT_W-1:0]       wvt_mag;

	// final clamp
	logic [VW-1:0] quot_res;
	logic          quot_sat;

	// result registers
	logic          done_q;
	logic [VW-1:0] res_q;
	logic          hit_out_q;
	logic          sat_out_q;

	assign busy = (state_q != isdi_pkg::ST_IDLE);

	// differences are exact in 25 bits; a hit is both differences zero
	assign dx_in   = isdi_pkg::DIFF_W'(sample_x) - isdi_pkg::DIFF_W'(query_x_q);
	assign dz_in   = isdi_pkg::DIFF_W'(sample_z) - isdi_pkg::DIFF_W'(query_z_q);
	assign new_hit = !hit_found_q && (dx_in == '0) && (dz_in == '0);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q <= '0;
			query_z_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				isdi_pkg::REG_QUERY_X: query_x_q <= cfg_wdata;
				isdi_pkg::REG_QUERY_Z: query_z_q <= cfg_wdata;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			isdi_pkg::ST_IDLE: begin
				if (start) begin
					// points after a hit, and the hit itself, skip the arithmetic
					if (hit_found_q || new_hit)
						state_d = last_point ? isdi_pkg::ST_FIN : isdi_pkg::ST_IDLE;
					else
						state_d = isdi_pkg::ST_SQ_X;
				end
			end
			isdi_pkg::ST_SQ_X:   state_d = isdi_pkg::ST_SQ_Z;
			isdi_pkg::ST_SQ_Z:   state_d = isdi_pkg::ST_D2_SUM;
			isdi_pkg::ST_D2_SUM: state_d = isdi_pkg::ST_DIV_W;
			isdi_pkg::ST_DIV_W: begin
				if (cnt_q == isdi_pkg::CNT_W'(1))
					state_d = isdi_pkg::ST_MUL_V;
			end
			isdi_pkg::ST_MUL_V:  state_d = isdi_pkg::ST_ACCUM;
			isdi_pkg::ST_ACCUM:  state_d = last_q ? isdi_pkg::ST_FIN : isdi_pkg::ST_IDLE;
			isdi_pkg::ST_FIN: begin
				if (hit_found_q || (wt_q == '0))
					state_d = isdi_pkg::ST_IDLE;
				else
					state_d = isdi_pkg::ST_DIV_R;
			end
			isdi_pkg::ST_DIV_R: begin
				if (cnt_q == isdi_pkg::CNT_W'(1))
					state_d = isdi_pkg::ST_RESULT;
			end
			isdi_pkg::ST_RESULT: state_d = isdi_pkg::ST_IDLE;
			default:             state_d = isdi_pkg::ST_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		ctl         = '0;
		ctl.mul_sel = isdi_pkg::MUL_DX;
		unique case (state_q)
			isdi_pkg::ST_IDLE:   ctl.capture = start;
			isdi_pkg::ST_SQ_X:   ctl.mul_sel = isdi_pkg::MUL_DX;
			isdi_pkg::ST_SQ_Z: begin
				ctl.mul_sel = isdi_pkg::MUL_DZ;
				ctl.d2_save = 1'b1;
			end
			isdi_pkg::ST_D2_SUM: ctl.wdiv_load = 1'b1;
			isdi_pkg::ST_DIV_W:  ctl.div_step = 1'b1;
			isdi_pkg::ST_MUL_V:  ctl.mul_sel = isdi_pkg::MUL_WV;
			isdi_pkg::ST_ACCUM:  ctl.acc_en = 1'b1;
			isdi_pkg::ST_FIN: begin
				ctl.fin_direct = hit_found_q || (wt_q == '0);
				ctl.rdiv_load  = !(hit_found_q || (wt_q == '0));
			end
			isdi_pkg::ST_DIV_R:  ctl.div_step = 1'b1;
			isdi_pkg::ST_RESULT: ctl.fin_quot = 1'b1;
			default:             ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= isdi_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// shared multiplier: dx*dx, dz*dz, then weight*value, registered
	assign weight = div_n_q[QW-1:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctl.mul_sel)
			isdi_pkg::MUL_DX: begin
				mul_a = MA_W'(dx_q);
				mul_b = dx_q;
			end
			isdi_pkg::MUL_DZ: begin
				mul_a = MA_W'(dz_q);
				mul_b = dz_q;
			end
			isdi_pkg::MUL_WV: begin
				mul_a = MA_W'($signed({1'b0, weight}));
				mul_b = isdi_pkg::DIFF_W'(value_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// one quotient bit per step: shift remainder and dividend left, subtract when it fits
	assign div_shift = {div_r_q, div_n_q[isdi_pkg::DIVN_W-1]};
	assign div_trial = {1'b0, div_shift} - {2'b00, div_d_q};
	assign div_ge    = !div_trial[isdi_pkg::D2_W+1];

	// datapath registers without reset
	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (ctl.capture) begin
			dx_q    <= dx_in;
			dz_q    <= dz_in;
			value_q <= sample_value;
			last_q  <= last_point;
		end
		if (ctl.d2_save)
			d2_q <= mul_q[isdi_pkg::SQ_W-1:0];
		if (ctl.wdiv_load) begin
			// dividend 2^WEIGHT_FRAC_BITS enters from the top, one bit per step
			div_r_q <= '0;
			div_d_q <= {1'b0, d2_q} + {1'b0, mul_q[isdi_pkg::SQ_W-1:0]};
			div_n_q <= {1'b1, {(isdi_pkg::DIVN_W-1){1'b0}}};
			cnt_q   <= isdi_pkg::CNT_W'(QW);
		end else if (ctl.rdiv_load) begin
			div_r_q <= '0;
			div_d_q <= isdi_pkg::D2_W'(wt_q);
			div_n_q <= wvt_mag;
			cnt_q   <= isdi_pkg::CNT_W'(isdi_pkg::DIVN_W);
			neg_q   <= wvt_q[isdi_pkg::WVT_W-1];
		end else if (ctl.div_step) begin
			div_r_q <= div_ge ? div_trial[isdi_pkg::D2_W-1:0] : div_shift[isdi_pkg::D2_W-1:0];
			div_n_q <= {div_n_q[isdi_pkg::DIVN_W-2:0], div_ge};
			cnt_q   <= cnt_q - isdi_pkg::CNT_W'(1);
		end
	end

	// saturating accumulation
	assign wt_sum  = {1'b0, wt_q} + (isdi_pkg::WT_W + 1)'(weight);
	assign wt_ovf  = wt_sum[isdi_pkg::WT_W];
	assign wvt_sum = (isdi_pkg::WVT_W + 1)'(wvt_q) + (isdi_pkg::WVT_W + 1)'(mul_q);
	assign wvt_ovf = wvt_sum[isdi_pkg::WVT_W] ^ wvt_sum[isdi_pkg::WVT_W-1];
	// magnitude of the most negative total still fits unsigned
	assign wvt_mag = wvt_q[isdi_pkg::WVT_W-1] ? (isdi_pkg::WVT_W'(0) - wvt_q) : wvt_q;

	// clamp the quotient to the signed output range
	always_comb begin
		quot_res = div_n_q[VW-1:0];
		quot_sat = 1'b0;
		if (neg_q) begin
			if ((|div_n_q[isdi_pkg::DIVN_W-1:VW]) ||
			    (div_n_q[VW-1] && (|div_n_q[VW-2:0]))) begin
				quot_res = {1'b1, {(VW-1){1'b0}}};
				quot_sat = 1'b1;
			end else begin
				quot_res = VW'(0) - div_n_q[VW-1:0];
			end
		end else if (|div_n_q[isdi_pkg::DIVN_W-1:VW-1]) begin
			quot_res = {1'b0, {(VW-1){1'b1}}};
			quot_sat = 1'b1;
		end
	end

	// set state: accumulators, hit record, overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wt_q        <= '0;
			wvt_q       <= '0;
			hit_found_q <= 1'b0;
			hit_value_q <= '0;
			ovf_q       <= 1'b0;
		end else if (ctl.fin_direct || ctl.fin_quot) begin
			// result goes out: start a fresh set
			wt_q        <= '0;
			wvt_q       <= '0;
			hit_found_q <= 1'b0;
			hit_value_q <= '0;
			ovf_q       <= 1'b0;
		end else begin
			if (ctl.capture && new_hit) begin
				hit_found_q <= 1'b1;
				hit_value_q <= sample_value;
			end
			if (ctl.acc_en) begin
				wt_q <= wt_ovf ? {isdi_pkg::WT_W{1'b1}} : wt_sum[isdi_pkg::WT_W-1:0];
				if (wvt_ovf)
					wvt_q <= wvt_sum[isdi_pkg::WVT_W] ?
						{1'b1, {(isdi_pkg::WVT_W-1){1'b0}}} :
						{1'b0, {(isdi_pkg::WVT_W-1){1'b1}}};
				else
					wvt_q <= wvt_sum[isdi_pkg::WVT_W-1:0];
				if (wt_ovf || wvt_ovf)
					ovf_q <= 1'b1;
			end
		end
	end

	// result strobe and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= ctl.fin_direct || ctl.fin_quot;
	end

	always_ff @(posedge clk) begin
		if (ctl.fin_direct) begin
			// exact hit returns its value; no weight at all returns zero
			res_q     <= hit_found_q ? hit_value_q : '0;
			hit_out_q <= hit_found_q;
			sat_out_q <= ovf_q;
		end else if (ctl.fin_quot) begin
			res_q     <= quot_res;
			hit_out_q <= 1'b0;
			sat_out_q <= ovf_q || quot_sat;
		end
	end

	assign done               = done_q;
	assign interpolated_value = res_q;
	assign exact_hit          = hit_out_q;
	assign saturated          = sat_out_q;

	// a result only appears once the sequencer is back to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// a closing point passes through the final state first, so results never come back to back
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	// every result clears the set it closes
	a_set_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (wt_q == '0) && (wvt_q == '0) && !hit_found_q && !ovf_q)
		else $error("set state not cleared after result");

	// the divider never runs with an exhausted step count
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == isdi_pkg::ST_DIV_W || state_q == isdi_pkg::ST_DIV_R) |-> (cnt_q != '0))
		else $error("divider step count underflow");

endmodule
